// ===== design/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared widths, limits, register indexes and types for the UTF-8 validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int ByteW   = 8;
    localparam int CountW  = 13;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 13;

    localparam logic [CountW-1:0] MaxCharsReset = 13'd160;
    localparam logic [CountW-1:0] MaxBytesReset = 13'd640;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_MAX_CHARS = 2'd0,
        REG_MAX_BYTES = 2'd1
    } reg_idx_t;

    // Limits handed from the register block to the checker
    typedef struct packed {
        logic [CountW-1:0] max_chars;
        logic [CountW-1:0] max_bytes;
    } limits_t;

endpackage

// ===== design/utf8v_if.sv =====
// ----------------------------------------------------------------------------
// utf8v interfaces
// Valid/ready channels: input bytes, result flag and configuration writes.
// ----------------------------------------------------------------------------
interface utf8v_byte_if;
    logic                      valid;
    logic                      ready;
    logic [utf8v_pkg::ByteW-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface utf8v_res_if;
    logic valid;
    logic ready;
    logic text_ok;

    modport source (output valid, output text_ok, input ready);
    modport sink   (input valid, input text_ok, output ready);
endinterface

interface utf8v_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [utf8v_pkg::CfgIdxW-1:0] index;
    logic [utf8v_pkg::CfgDatW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/utf8v_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// utf8v_cfg_regs
// Character and byte limit registers, written over the config channel.
// ----------------------------------------------------------------------------
module utf8v_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    utf8v_cfg_if.sink            cfg,
    output utf8v_pkg::limits_t   limits
);
    import utf8v_pkg::*;

    limits_t limits_reg;
    limits_t limits_next;

    assign cfg.ready = 1'b1;
    assign limits    = limits_reg;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_CHARS: limits_next.max_chars = cfg.data;
                REG_MAX_BYTES: limits_next.max_bytes = cfg.data;
                default:       limits_next = limits_reg; // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.max_chars <= MaxCharsReset;
            limits_reg.max_bytes <= MaxBytesReset;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

endmodule

// ===== design/utf8v_in_stage.sv =====
// ----------------------------------------------------------------------------
// utf8v_in_stage
// Input register for the byte stream; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module utf8v_in_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    utf8v_byte_if.sink                  text_in,
    input  logic                        take,
    output logic                        held_valid,
    output logic [utf8v_pkg::ByteW-1:0] held_byte
);
    import utf8v_pkg::*;

    logic             valid_reg;
    logic [ByteW-1:0] byte_reg;

    assign text_in.ready = !valid_reg || take;
    assign held_valid    = valid_reg;
    assign held_byte     = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            byte_reg <= text_in.text_byte;
        end
    end

endmodule

// ===== design/utf8v_core.sv =====
// ----------------------------------------------------------------------------
// utf8v_core
// Per-string decode state, UTF-8 checks and the registered result flag.
// ----------------------------------------------------------------------------
module utf8v_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        held_valid,
    input  logic [utf8v_pkg::ByteW-1:0] held_byte,
    input  utf8v_pkg::limits_t          limits,
    output logic                        take,
    utf8v_res_if.source                 result
);
    import utf8v_pkg::*;

    logic [CountW-1:0] bytes_reg,   bytes_next;
    logic [CountW-1:0] chars_reg,   chars_next;
    logic [1:0]        pending_reg, pending_next;
    logic [2:0]        len_reg,     len_next;
    logic [20:0]       acc_reg,     acc_next;
    logic              failed_reg,  failed_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg,    out_ok_next;

    logic              is_term;

    function automatic logic cp_bad(input logic [20:0] cp, input logic [2:0] len);
        logic bad;
        bad = 1'b0;
        if (len == 3'd2 && cp < 21'h80)    bad = 1'b1;
        if (len == 3'd3 && cp < 21'h800)   bad = 1'b1;
        if (len == 3'd4 && cp < 21'h10000) bad = 1'b1;
        if (cp > 21'h10ffff)               bad = 1'b1;
        if (cp >= 21'hd800 && cp <= 21'hdfff) bad = 1'b1;
        if (cp < 21'h20)                   bad = 1'b1;
        if (cp >= 21'h7f && cp <= 21'h9f)  bad = 1'b1;
        return bad;
    endfunction

    assign is_term = (held_byte == '0);
    // terminator needs the result register free, other bytes always go
    assign take    = held_valid && (!is_term || !out_valid_reg || result.ready);

    assign result.valid   = out_valid_reg;
    assign result.text_ok = out_ok_reg;

    always_comb
    begin
        logic [CountW:0] bsum;
        logic [CountW:0] csum;
        logic            finish;
        logic [20:0]     fin_cp;
        logic [2:0]      fin_len;

        bytes_next     = bytes_reg;
        chars_next     = chars_reg;
        pending_next   = pending_reg;
        len_next       = len_reg;
        acc_next       = acc_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_ok_next    = out_ok_reg;
        finish         = 1'b0;
        fin_cp         = acc_reg;
        fin_len        = len_reg;
        bsum           = {1'b0, bytes_reg} + 1'b1;
        csum           = {1'b0, chars_reg} + 1'b1;

        if (take)
        begin
            if (is_term)
            begin
                out_valid_next = 1'b1;
                out_ok_next    = !failed_reg && (bytes_reg != '0) && (pending_reg == 2'd0);
                bytes_next     = '0;
                chars_next     = '0;
                pending_next   = 2'd0;
                len_next       = 3'd0;
                acc_next       = '0;
                failed_next    = 1'b0;
            end
            else if (!failed_reg)
            begin
                bytes_next = bsum[CountW] ? {CountW{1'b1}} : bsum[CountW-1:0];
                if (bsum > {1'b0, limits.max_bytes})
                begin
                    failed_next = 1'b1;
                end
                else if (pending_reg != 2'd0)
                begin
                    if (held_byte[7:6] != 2'b10)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        acc_next     = {acc_reg[14:0], held_byte[5:0]};
                        pending_next = pending_reg - 2'd1;
                        finish       = (pending_reg == 2'd1);
                        fin_cp       = {acc_reg[14:0], held_byte[5:0]};
                        fin_len      = len_reg;
                    end
                end
                else
                begin
                    priority if (held_byte < 8'h80)
                    begin
                        acc_next = {13'd0, held_byte};
                        len_next = 3'd1;
                        finish   = 1'b1;
                        fin_cp   = {13'd0, held_byte};
                        fin_len  = 3'd1;
                    end
                    else if (held_byte >= 8'hc2 && held_byte <= 8'hdf)
                    begin
                        acc_next     = {16'd0, held_byte[4:0]};
                        len_next     = 3'd2;
                        pending_next = 2'd1;
                    end
                    else if (held_byte >= 8'he0 && held_byte <= 8'hef)
                    begin
                        acc_next     = {17'd0, held_byte[3:0]};
                        len_next     = 3'd3;
                        pending_next = 2'd2;
                    end
                    else if (held_byte >= 8'hf0 && held_byte <= 8'hf4)
                    begin
                        acc_next     = {18'd0, held_byte[2:0]};
                        len_next     = 3'd4;
                        pending_next = 2'd3;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end

                // completed character: code point checks, then char limit
                if (finish)
                begin
                    if (cp_bad(fin_cp, fin_len))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (csum > {1'b0, limits.max_chars})
                        begin
                            failed_next = 1'b1;
                        end
                        chars_next = csum[CountW] ? {CountW{1'b1}} : csum[CountW-1:0];
                        len_next   = 3'd0;
                        acc_next   = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg     <= '0;
            chars_reg     <= '0;
            pending_reg   <= 2'd0;
            len_reg       <= 3'd0;
            acc_reg       <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bytes_reg     <= bytes_next;
            chars_reg     <= chars_next;
            pending_reg   <= pending_next;
            len_reg       <= len_next;
            acc_reg       <= acc_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ok_reg <= out_ok_next;
    end

endmodule

// ===== design/utf8_text_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_text_validator
// Byte-stream UTF-8 string checker with character and byte limits.
// ----------------------------------------------------------------------------
// Usage:
//   text_in : one string byte per transaction; a zero byte terminates the
//             string. Bytes before the terminator produce no result.
//   result  : one transaction per terminator, text_ok = 1 if the string was
//             non-empty, well-formed UTF-8, free of controls, surrogates and
//             overlong forms, within both limits and not cut mid-sequence.
//   cfg     : index 0 = max_chars, index 1 = max_bytes; other indexes are
//             ignored. Write only while no string is in flight.
// Throughput: one byte per cycle, unless a terminator waits for the result
//   register. The per-byte decode is a single layer of logic between the
//   input register and the state/result registers. A terminator passes the
//   input register, then the result register, before result.valid rises.
// Stall: while the result waits on result.ready, ordinary bytes of the next
//   string keep flowing; a second terminator holds in the input register,
//   and text_in.ready drops only then.
// Reset: limits return to 160 characters / 640 bytes, string state clears,
//   no result pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_text_validator (
    input  logic         clk,
    input  logic         rst_n,
    utf8v_byte_if.sink   text_in,
    utf8v_res_if.source  result,
    utf8v_cfg_if.sink    cfg
);
    import utf8v_pkg::*;

    limits_t          limits;
    logic             take;
    logic             held_valid;
    logic [ByteW-1:0] held_byte;

    // limit registers
    utf8v_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    // input register; accepts a new byte whenever it is empty or the core drains it
    utf8v_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    // decode, checks, sticky error and result register
    utf8v_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .limits     (limits),
        .take       (take),
        .result     (result)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_text_validator. A short table of directed
// strings runs first. Random UTF-8 text with injected flaws follows, under
// several limit settings and flow-control patterns. Verdicts are scored against a
// behavioral decoder kept in the bench, or typed into the directed table.
// ----------------------------------------------------------------------------
module tb_top;
    import utf8v_pkg::*;

    // Longest stretch with no transaction on any channel before we give up.
    // The worst legal case is the receiver hold-off plus a sender gap.
    localparam int QuietLimit  = 5000;
    localparam int HoldCycles  = 300;  // receiver hold-off for the pressure phase
    localparam int DrainCycles = 4;    // settling time after the last verdict is in
    localparam int MaxReports  = 10;

    // Spare register indexes: writes there must not touch either limit
    localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
    localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

    // Boundary code points for the well-formed generator
    localparam logic [20:0] CpEdges [10] = '{
        21'h20, 21'h7E, 21'hA0, 21'h7FF, 21'h800,
        21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF
    };

    // How a terminator's verdict is predicted
    typedef enum logic [1:0] {
        TERM_NONE,   // not a terminator
        TERM_FAIL,   // typed in: string must be rejected
        TERM_PASS,   // typed in: string must be accepted
        TERM_MODEL   // taken from the decoder below
    } term_check_t;

    typedef struct {
        logic [7:0]  b;
        term_check_t chk;
    } dir_row_t;

    typedef struct {
        int chars;        // max_chars to program
        int bytes;        // max_bytes to program
        int send_pct;     // sender idle, percent of cycles
        int recv_pct;     // receiver stall, percent of cycles
        int budget;       // bytes to send in this phase
        int max_len;      // most characters or flaws per random string; noise strings excepted
        bit pressure;     // long receiver hold-off at phase start
        bit probe_spare;  // write the unused register indexes too
        bit rand_limits;  // pick small random limits instead
    } phase_t;

    logic clk;
    logic rst_n;

    utf8v_byte_if text_if ();
    utf8v_res_if  res_if ();
    utf8v_cfg_if  cfg_if ();

    utf8_text_validator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_if),
        .result  (res_if),
        .cfg     (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Directed strings at the reset limits (160 chars / 640 bytes)
    // ------------------------------------------------------------------------
    dir_row_t dir_rows [26] = '{
        '{8'h00, TERM_FAIL},                        // empty string
        '{8'h41, TERM_NONE}, '{8'h00, TERM_PASS},   // plain ASCII
        // top of the two-byte range, U+07FF
        '{8'hDF, TERM_NONE}, '{8'hBF, TERM_NONE}, '{8'h00, TERM_PASS},
        // highest scalar value, U+10FFFF
        '{8'hF4, TERM_NONE}, '{8'h8F, TERM_NONE}, '{8'hBF, TERM_NONE},
        '{8'hBF, TERM_NONE}, '{8'h00, TERM_PASS},
        // bad lead byte, then a good byte that must not revive the string
        '{8'hFF, TERM_NONE}, '{8'h41, TERM_NONE}, '{8'h00, TERM_FAIL},
        // string cut inside a three-byte sequence
        '{8'hE2, TERM_NONE}, '{8'h82, TERM_NONE}, '{8'h00, TERM_FAIL},
        // lead byte followed by a non-continuation
        '{8'hC3, TERM_NONE}, '{8'h41, TERM_NONE}, '{8'h00, TERM_FAIL},
        // C1 control U+0080, overlong lead C0
        '{8'hC2, TERM_NONE}, '{8'h80, TERM_NONE}, '{8'h00, TERM_MODEL},
        '{8'hC0, TERM_NONE}, '{8'h80, TERM_NONE}, '{8'h00, TERM_FAIL}
    };

    // ------------------------------------------------------------------------
    // Random phases: limit extremes, idle/stall mixes, one pressure phase
    // ------------------------------------------------------------------------
    phase_t phase_plan [8] = '{
        '{160,  640,  0,  0,  80,  8, 1'b0, 1'b0, 1'b0},
        '{0,    8191, 80, 0,  40,  4, 1'b0, 1'b0, 1'b0},  // zero char limit
        '{8191, 0,    0,  80, 40,  4, 1'b0, 1'b0, 1'b0},  // zero byte limit
        '{3,    8,    23, 23, 90,  5, 1'b0, 1'b1, 1'b0},  // limits hit often
        '{1,    1,    0,  0,  40,  2, 1'b0, 1'b0, 1'b0},
        '{4096, 4096, 0,  0,  100, 6, 1'b1, 1'b0, 1'b0},  // backpressure
        '{8191, 8191, 80, 80, 90,  10, 1'b0, 1'b0, 1'b0},
        '{0,    0,    23, 23, 100, 8, 1'b0, 1'b0, 1'b1}
    };

    // ------------------------------------------------------------------------
    // Decoder state mirrored from the block
    // ------------------------------------------------------------------------
    logic [CountW-1:0] lim_chars;
    logic [CountW-1:0] lim_bytes;
    logic [CountW-1:0] cnt_bytes;
    logic [CountW-1:0] cnt_chars;
    logic [1:0]        cont_left;   // continuation bytes still owed
    logic [2:0]        seq_len;
    logic [20:0]       cp_acc;
    bit                str_failed;

    // Verdicts owed by the block, oldest first
    bit          ok_expect_q [$];
    // Check mode for each terminator handed to the block, oldest first
    term_check_t term_chk_q [$];
    // Bytes of the string being built
    logic [7:0]  str_bytes [$];

    int errors       = 0;
    int quiet_cycles = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;

    function automatic bit cp_rejected(input logic [20:0] cp, input logic [2:0] len);
        return (len == 3'd2 && cp < 21'h80) || (len == 3'd3 && cp < 21'h800) ||
               (len == 3'd4 && cp < 21'h10000) || cp > 21'h10FFFF ||
               (cp >= 21'hD800 && cp <= 21'hDFFF) || cp < 21'h20 ||
               (cp >= 21'h7F && cp <= 21'h9F);
    endfunction

    function automatic void clear_scan();
        cnt_bytes  = '0;
        cnt_chars  = '0;
        cont_left  = '0;
        seq_len    = '0;
        cp_acc     = '0;
        str_failed = 1'b0;
    endfunction

    // A character is complete: screen the code point, then count it
    function automatic void close_char();
        int n;
        if (cp_rejected(cp_acc, seq_len)) begin
            str_failed = 1'b1;
            return;
        end
        n = int'(cnt_chars) + 1;
        if (n > int'(lim_chars))
            str_failed = 1'b1;
        cnt_chars = (n > 8191) ? 13'h1FFF : CountW'(n);
        seq_len   = '0;
        cp_acc    = '0;
    endfunction

    // Feed one byte; returns 1 with the verdict in ok when the string ends
    function automatic bit scan_byte(input logic [7:0] b, output bit ok);
        int n;
        ok = 1'b0;
        if (b == 8'h00) begin
            ok = !str_failed && cnt_bytes != '0 && cont_left == '0;
            clear_scan();
            return 1'b1;
        end
        if (str_failed)
            return 1'b0;

        // byte limit is checked before the byte is decoded
        n = int'(cnt_bytes) + 1;
        if (n > int'(lim_bytes))
            str_failed = 1'b1;
        cnt_bytes = (n > 8191) ? 13'h1FFF : CountW'(n);
        if (str_failed)
            return 1'b0;

        if (cont_left != '0) begin
            if (b[7:6] != 2'b10) begin
                str_failed = 1'b1;
                return 1'b0;
            end
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == '0)
                close_char();
            return 1'b0;
        end

        if (b < 8'h80) begin
            cp_acc  = 21'(b);
            seq_len = 3'd1;
            close_char();
        end
        else if (b >= 8'hC2 && b <= 8'hDF) begin
            cp_acc    = 21'(b[4:0]);
            seq_len   = 3'd2;
            cont_left = 2'd1;
        end
        else if (b >= 8'hE0 && b <= 8'hEF) begin
            cp_acc    = 21'(b[3:0]);
            seq_len   = 3'd3;
            cont_left = 2'd2;
        end
        else if (b >= 8'hF0 && b <= 8'hF4) begin
            cp_acc    = 21'(b[2:0]);
            seq_len   = 3'd4;
            cont_left = 2'd3;
        end
        else begin
            str_failed = 1'b1;   // 80-C1 or F5-FF as a lead
        end
        return 1'b0;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MaxReports)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, plus a long hold-off on request so the
    // block fills up and has to stall its byte input.
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HoldCycles;
            end
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else begin
                res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every transaction seen at a rising edge, on values from
    // before that edge. Config writes update the decoder's limits, accepted
    // bytes step the decoder, accepted results are scored.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        bit          ok;
        bit          want;
        bit          done;
        bit          moved;
        term_check_t chk;
        moved = 1'b0;
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                moved = 1'b1;
                case (cfg_if.index)
                    REG_MAX_CHARS: lim_chars = cfg_if.data;
                    REG_MAX_BYTES: lim_bytes = cfg_if.data;
                    default: ;   // spare indexes are ignored
                endcase
            end

            if (text_if.valid && text_if.ready) begin
                moved = 1'b1;
                done  = scan_byte(text_if.text_byte, ok);
                if (done) begin
                    chk = (term_chk_q.size() != 0) ? term_chk_q.pop_front() : TERM_MODEL;
                    // typed-in verdicts stand on their own
                    if (chk == TERM_PASS)
                        ok = 1'b1;
                    else if (chk == TERM_FAIL)
                        ok = 1'b0;
                    ok_expect_q.push_back(ok);
                end
            end

            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                if (ok_expect_q.size() == 0) begin
                    flag_error($sformatf("result with nothing pending, text_ok=%0b",
                                         res_if.text_ok));
                end
                else begin
                    want = ok_expect_q.pop_front();
                    if (res_if.text_ok !== want)
                        flag_error($sformatf("text_ok expected %0b got %0b",
                                             want, res_if.text_ok));
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    // Watchdog: nothing moved for too long
    initial
    begin : watchdog
        wait (quiet_cycles >= QuietLimit);
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One byte transaction. Called at a rising edge; returns at the edge that
    // accepted it, with valid still high so back-to-back bytes need no dip.
    task automatic send_byte(input logic [7:0] b, input term_check_t chk);
        if ($urandom_range(99) < send_idle_pct) begin
            text_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        if (b == 8'h00)
            term_chk_q.push_back(chk);
        text_if.valid     <= 1'b1;
        text_if.text_byte <= b;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
    endtask

    // Config write; caller drops valid after the last one
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    // Wait until every verdict is in, then let the pipeline settle
    task automatic drain();
        @(posedge clk);
        while (ok_expect_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic push_cp(input logic [20:0] cp, input int len);
        case (len)
            1: str_bytes.push_back({1'b0, cp[6:0]});
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back({2'b10, cp[17:12]});
                str_bytes.push_back({2'b10, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Legal character: random from each encoding length, or a boundary value
    task automatic push_good_char();
        logic [20:0] cp;
        case ($urandom_range(4))
            0: push_cp(21'($urandom_range(8'h20, 8'h7E)), 1);
            1: push_cp(21'($urandom_range(11'h0A0, 11'h7FF)), 2);
            2: begin
                cp = 21'($urandom_range(16'h0800, 16'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp - 21'h1000;   // step out of the surrogates
                push_cp(cp, 3);
            end
            3: push_cp(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
            default: begin
                cp = CpEdges[$urandom_range(9)];
                push_cp(cp, (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 :
                            (cp < 21'h10000) ? 3 : 4);
            end
        endcase
    endtask

    // One malformed or forbidden piece of text, or one random nonzero byte
    task automatic push_flaw();
        int len;
        case ($urandom_range(8))
            0: str_bytes.push_back(8'($urandom_range(1, 255)));
            1: begin   // bad lead byte
                if ($urandom_range(1))
                    str_bytes.push_back(8'($urandom_range(8'h80, 8'hC1)));
                else
                    str_bytes.push_back(8'($urandom_range(8'hF5, 8'hFF)));
            end
            2: begin   // truncated sequence
                push_cp(21'($urandom_range(16'h0800, 16'hFFFF)), 3);
                void'(str_bytes.pop_back());
                if ($urandom_range(1))
                    void'(str_bytes.pop_back());
            end
            3: begin   // overlong form
                len = $urandom_range(2, 4);
                push_cp(21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF)),
                        len);
            end
            4: push_cp(21'($urandom_range(16'hD800, 16'hDFFF)), 3);   // surrogate
            5: push_cp(21'($urandom_range(1, 8'h1F)), 1);              // C0 control
            6: begin   // DEL or C1 control
                if ($urandom_range(1))
                    str_bytes.push_back(8'h7F);
                else
                    push_cp(21'($urandom_range(8'h80, 8'h9F)), 2);
            end
            7: push_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);  // past U+10FFFF
            default: str_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));  // stray cont.
        endcase
    endtask

    // Build one string: mostly well-formed text, some flaws, some noise
    task automatic make_string(input int max_len);
        int n;
        int pick;
        str_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 5) begin
            // empty string, terminator only
        end
        else if (pick < 15) begin
            n = $urandom_range(1, 8);
            repeat (n) str_bytes.push_back(8'($urandom_range(1, 255)));
        end
        else begin
            n = $urandom_range(1, max_len);
            repeat (n)
            begin
                if ($urandom_range(99) < 12)
                    push_flaw();
                else
                    push_good_char();
            end
        end
        str_bytes.push_back(8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int sent;
        int lc;
        int lb;

        rst_n             = 1'b0;
        text_if.valid     = 1'b0;
        text_if.text_byte = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        lim_chars         = MaxCharsReset;
        lim_bytes         = MaxBytesReset;
        clear_scan();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset limits, no idling
        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].chk);
        text_if.valid <= 1'b0;
        drain();

        // random phases; limits only change while nothing is in flight
        foreach (phase_plan[p])
        begin
            lc = phase_plan[p].chars;
            lb = phase_plan[p].bytes;
            if (phase_plan[p].rand_limits) begin
                lc = $urandom_range(1, 12);
                lb = $urandom_range(1, 30);
            end
            write_reg(REG_MAX_CHARS, CfgDatW'(lc));
            write_reg(REG_MAX_BYTES, CfgDatW'(lb));
            if (phase_plan[p].probe_spare) begin
                // zero through a spare index would wreck every string if decoded
                write_reg(RegSpareLo, '0);
                write_reg(RegSpareHi, '0);
            end
            cfg_if.valid <= 1'b0;

            send_idle_pct  = phase_plan[p].send_pct;
            recv_stall_pct = phase_plan[p].recv_pct;
            if (phase_plan[p].pressure)
                hold_req <= 1'b1;

            sent = 0;
            while (sent < phase_plan[p].budget)
            begin
                make_string(phase_plan[p].max_len);
                foreach (str_bytes[i])
                    send_byte(str_bytes[i], TERM_MODEL);
                sent += str_bytes.size();
            end
            text_if.valid <= 1'b0;
            drain();
        end

        if (ok_expect_q.size() != 0)
            flag_error($sformatf("%0d verdicts never arrived", ok_expect_q.size()));

        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
